FILE: hw/rtl/fpdc_pkg.sv
`default_nettype none

package fpdc_pkg;

  // Fixed-point unity for the normalized error and change values (Q1.14).
  localparam logic [14:0] Q_ONE = 15'd16384;
  localparam logic [13:0] Q_HALF = 14'd8192;

  // Fuzzy sets per input and the number of restoring division steps.
  localparam int NSETS = 5;
  localparam int DIV_STEPS = 15;

  // Position of each stage in the valid shift line.
  localparam int VI_NORM = DIV_STEPS + 1;
  localparam int VI_MU = VI_NORM + 1;
  localparam int VI_FIRE = VI_MU + 1;
  localparam int VI_ROW = VI_FIRE + 1;
  localparam int VI_SUM = VI_ROW + 1;
  localparam int VI_MUL = VI_SUM + 1;
  localparam int NSTAGES = VI_MUL + DIV_STEPS + 1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ERROR_SCALE = 2'd0;
  localparam logic [1:0] REG_ERROR_RATE_SCALE = 2'd1;
  localparam logic [1:0] REG_OUTPUT_SCALE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [14:0] ERROR_SCALE_RST = 15'd4096;
  localparam logic [14:0] ERROR_RATE_SCALE_RST = 15'd4096;
  localparam logic [14:0] OUTPUT_SCALE_RST = 15'd500;

  // Output set codes: negative big, negative small, zero, positive small, positive big.
  localparam logic [2:0] SET_NB = 3'd0;
  localparam logic [2:0] SET_NS = 3'd1;
  localparam logic [2:0] SET_ZE = 3'd2;
  localparam logic [2:0] SET_PS = 3'd3;
  localparam logic [2:0] SET_PB = 3'd4;

  // Centers of the five triangular input sets.
  localparam logic signed [16:0] SET_CENTER [NSETS] = '{
    -17'sd16384, -17'sd8192, 17'sd0, 17'sd8192, 17'sd16384
  };

  // Rule base: row is the error set, column the error change set.
  localparam logic [2:0] RULE_MAP [NSETS][NSETS] = '{
    '{SET_NB, SET_NB, SET_NB, SET_NS, SET_ZE},
    '{SET_NB, SET_NB, SET_NS, SET_ZE, SET_PS},
    '{SET_NB, SET_NS, SET_ZE, SET_PS, SET_PB},
    '{SET_NS, SET_ZE, SET_PS, SET_PB, SET_PB},
    '{SET_ZE, SET_PS, SET_PB, SET_PB, SET_PB}
  };

  // One input normalization in flight through the front divider.
  typedef struct packed {
    logic [29:0] rem;
    logic [14:0] quo;
    logic        neg;
    logic        sat;
    logic        zero;
  } fdiv_t;

  // The weighted average in flight through the back divider.
  typedef struct packed {
    logic [34:0] rem;
    logic [19:0] dvs;
    logic [14:0] quo;
    logic        neg;
    logic        dz;
  } bdiv_t;

  // One restoring division step of the normalization, quotient bit idx.
  function automatic fdiv_t fdiv_step(input fdiv_t cur, input logic [14:0] dvs,
                                      input logic [3:0] idx);
    fdiv_t       res;
    logic [29:0] sub;
    res = cur;
    sub = {15'd0, dvs} << idx;
    if (cur.rem >= sub) begin
      res.rem = cur.rem - sub;
      res.quo[idx] = 1'b1;
    end
    return res;
  endfunction

  // One restoring division step of the output average, quotient bit idx.
  function automatic bdiv_t bdiv_step(input bdiv_t cur, input logic [3:0] idx);
    bdiv_t       res;
    logic [34:0] sub;
    res = cur;
    sub = {15'd0, cur.dvs} << idx;
    if (cur.rem >= sub) begin
      res.rem = cur.rem - sub;
      res.quo[idx] = 1'b1;
    end
    return res;
  endfunction

  // Signed normalized value from the finished quotient, clamped to one.
  function automatic logic signed [15:0] fnorm(input fdiv_t cur);
    logic [14:0] mag;
    if (cur.zero) begin
      mag = '0;
    end else if (cur.sat || (cur.quo > Q_ONE)) begin
      mag = Q_ONE;
    end else begin
      mag = cur.quo;
    end
    return cur.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Triangular membership of x in the set centered at SET_CENTER[idx].
  function automatic logic [14:0] fuzz_mu(input logic signed [15:0] x, input logic [2:0] idx);
    logic signed [16:0] dif;
    logic [15:0]        adif;
    dif = {x[15], x} - SET_CENTER[idx];
    adif = dif[16] ? 16'(-dif) : dif[15:0];
    if (adif >= {2'b00, Q_HALF}) begin
      return '0;
    end
    return Q_ONE - {1'b0, adif[12:0], 1'b0};
  endfunction

  // Firing strength times the singleton weight, in half units.
  function automatic logic signed [18:0] rule_term(input logic [14:0] f, input logic [2:0] code);
    logic signed [18:0] fx;
    logic signed [18:0] term;
    fx = $signed({4'd0, f});
    unique case (code)
      SET_NB:  term = -(fx <<< 1);
      SET_NS:  term = -fx;
      SET_ZE:  term = '0;
      SET_PS:  term = fx;
      SET_PB:  term = fx <<< 1;
      default: term = '0;
    endcase
    return term;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fuzzy_pd_controller_5x5.sv
// Fuzzy PD controller with a 5x5 rule base and singleton output. Each input word
// carries an error and an error change sample; each is divided by its full-scale
// register and clamped to plus or minus one, fuzzified into five triangular sets,
// and the 25 rules give a weighted average that is scaled by output_scale and
// truncated toward zero. The block keeps no state between words. One word is taken
// every clock cycle while the output buffer has a free entry. The pipeline holds an
// input register, two 15-step pipelined restoring dividers (one for the input
// normalization, one for the final average) plus six arithmetic stages and the
// output register. A two-entry output buffer lets the pipeline keep taking words
// while a result waits; when both entries are full the whole pipeline holds.
// Registers: error_scale at 0x0, error_rate_scale at 0x4, output_scale at 0x8.
`default_nettype none

module fuzzy_pd_controller_5x5
  import fpdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] error, [31:16] error_change
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // [15:0] drive
);

  // Configuration registers.
  logic [14:0] error_scale;
  logic [14:0] error_rate_scale;
  logic [14:0] output_scale;

  // Pipeline control.
  logic [NSTAGES-1:0] vld;
  logic               adv;
  logic               pipe_out;

  // Pipeline payload.
  fdiv_t              fe [DIV_STEPS+1];
  fdiv_t              fd [DIV_STEPS+1];
  logic signed [15:0] nrm_e;
  logic signed [15:0] nrm_d;
  logic [14:0]        mu_e [NSETS];
  logic [14:0]        mu_d [NSETS];
  logic [14:0]        fire [NSETS][NSETS];
  logic signed [18:0] rnum [NSETS];
  logic [16:0]        rden [NSETS];
  logic signed [20:0] num2;
  logic [18:0]        den;
  bdiv_t              bd [DIV_STEPS+1];

  // Output buffer.
  logic               out_vld;
  logic [15:0]        out_data;
  logic               skid_vld;
  logic [15:0]        skid_data;
  logic [15:0]        drive_next;

  // Input word fields.
  logic [15:0]        err_in;
  logic [15:0]        derr_in;
  logic [15:0]        err_mag;
  logic [15:0]        derr_mag;

  // Membership sum used by the checks.
  logic [16:0]        mu_sum_e;

  // Configuration writes and reads.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_scale <= ERROR_SCALE_RST;
      error_rate_scale <= ERROR_RATE_SCALE_RST;
      output_scale <= OUTPUT_SCALE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ERROR_SCALE:      error_scale <= pwdata[14:0];
        REG_ERROR_RATE_SCALE: error_rate_scale <= pwdata[14:0];
        REG_OUTPUT_SCALE:     output_scale <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ERROR_SCALE:      prdata = {17'd0, error_scale};
      REG_ERROR_RATE_SCALE: prdata = {17'd0, error_rate_scale};
      REG_OUTPUT_SCALE:     prdata = {17'd0, output_scale};
      default:              prdata = '0;
    endcase
  end

  // The pipeline moves as a whole while the output buffer has a free entry.
  assign adv = !skid_vld;
  assign s_tready = adv;
  assign pipe_out = adv && vld[NSTAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGES-2:0], s_tvalid};
    end
  end

  // Magnitudes of the input samples.
  assign err_in = s_tdata[15:0];
  assign derr_in = s_tdata[31:16];
  assign err_mag = err_in[15] ? (~err_in + 16'd1) : err_in;
  assign derr_mag = derr_in[15] ? (~derr_in + 16'd1) : derr_in;

  // Payload stages; each loads together with its valid bit.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Input capture: the dividend is the magnitude times one in Q1.14.
      fe[0].rem <= {err_mag, 14'd0};
      fe[0].quo <= '0;
      fe[0].neg <= err_in[15];
      fe[0].sat <= err_mag >= {error_scale, 1'b0};
      fe[0].zero <= err_mag == 16'd0;
      fd[0].rem <= {derr_mag, 14'd0};
      fd[0].quo <= '0;
      fd[0].neg <= derr_in[15];
      fd[0].sat <= derr_mag >= {error_rate_scale, 1'b0};
      fd[0].zero <= derr_mag == 16'd0;

      // Normalization divider, one quotient bit per stage, top bit first.
      for (int j = 1; j <= DIV_STEPS; j++) begin
        fe[j] <= fdiv_step(fe[j-1], error_scale, 4'(DIV_STEPS - j));
        fd[j] <= fdiv_step(fd[j-1], error_rate_scale, 4'(DIV_STEPS - j));
      end

      // Signed normalized values.
      nrm_e <= fnorm(fe[DIV_STEPS]);
      nrm_d <= fnorm(fd[DIV_STEPS]);

      // Memberships of both inputs in the five sets.
      for (int i = 0; i < NSETS; i++) begin
        mu_e[i] <= fuzz_mu(nrm_e, 3'(i));
        mu_d[i] <= fuzz_mu(nrm_d, 3'(i));
      end

      // Firing strength of every rule is the smaller membership.
      for (int r = 0; r < NSETS; r++) begin
        for (int c = 0; c < NSETS; c++) begin
          fire[r][c] <= (mu_e[r] < mu_d[c]) ? mu_e[r] : mu_d[c];
        end
      end

      // Weighted and plain sums per error set.
      for (int r = 0; r < NSETS; r++) begin
        rnum[r] <= rule_term(fire[r][0], RULE_MAP[r][0]) + rule_term(fire[r][1], RULE_MAP[r][1])
                 + rule_term(fire[r][2], RULE_MAP[r][2]) + rule_term(fire[r][3], RULE_MAP[r][3])
                 + rule_term(fire[r][4], RULE_MAP[r][4]);
        rden[r] <= {2'b00, fire[r][0]} + {2'b00, fire[r][1]} + {2'b00, fire[r][2]}
                 + {2'b00, fire[r][3]} + {2'b00, fire[r][4]};
      end

      // Totals over all rules.
      num2 <= {{2{rnum[0][18]}}, rnum[0]} + {{2{rnum[1][18]}}, rnum[1]}
            + {{2{rnum[2][18]}}, rnum[2]} + {{2{rnum[3][18]}}, rnum[3]}
            + {{2{rnum[4][18]}}, rnum[4]};
      den <= {2'b00, rden[0]} + {2'b00, rden[1]} + {2'b00, rden[2]}
           + {2'b00, rden[3]} + {2'b00, rden[4]};

      // Scale the weighted sum; the divisor is twice the strength sum.
      bd[0].rem <= {15'd0, (num2[20] ? 20'(-num2) : num2[19:0])} * {20'd0, output_scale};
      bd[0].dvs <= {den, 1'b0};
      bd[0].quo <= '0;
      bd[0].neg <= num2[20];
      bd[0].dz <= den == 19'd0;

      // Output divider, one quotient bit per stage.
      for (int j = 1; j <= DIV_STEPS; j++) begin
        bd[j] <= bdiv_step(bd[j-1], 4'(DIV_STEPS - j));
      end
    end
  end

  // Apply the sign; no firing rule gives zero drive.
  always_comb begin
    if (bd[DIV_STEPS].dz) begin
      drive_next = '0;
    end else if (bd[DIV_STEPS].neg) begin
      drive_next = -{1'b0, bd[DIV_STEPS].quo};
    end else begin
      drive_next = {1'b0, bd[DIV_STEPS].quo};
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_vld && m_tready) begin
      if (skid_vld) begin
        skid_vld <= 1'b0;
      end else begin
        out_vld <= pipe_out;
      end
    end else if (!out_vld) begin
      out_vld <= pipe_out;
    end else if (pipe_out) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld && m_tready) begin
      if (skid_vld) begin
        out_data <= skid_data;
      end else if (pipe_out) begin
        out_data <= drive_next;
      end
    end else if (!out_vld) begin
      if (pipe_out) begin
        out_data <= drive_next;
      end
    end else if (pipe_out) begin
      skid_data <= drive_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata = out_data;

  // Checks.
  assign mu_sum_e = {2'b00, mu_e[0]} + {2'b00, mu_e[1]} + {2'b00, mu_e[2]}
                  + {2'b00, mu_e[3]} + {2'b00, mu_e[4]};

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry holds a word while the output register is empty");

  // A result leaving the pipeline into a stalled output lands in the skid entry.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (pipe_out && out_vld && !m_tready) |=> skid_vld)
    else $error("pipeline result dropped while the output was stalled");

  // The memberships of a clamped input always add up to one.
  a_mu_partition: assert property (@(posedge clk) disable iff (rst)
    vld[VI_MU] |-> (mu_sum_e == {2'b00, Q_ONE}))
    else $error("error memberships do not sum to one");

endmodule

`default_nettype wire
